/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check macros. Clock is clock, reset is reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define CRST_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("check failed");

// Antecedent on one edge implies consequent on the next edge.
`define CRST_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/crst_pkg.sv */
// ----------------------------------------------------------------------------
// crst_pkg
// Types and constants shared by the spline tessellator modules.
// ----------------------------------------------------------------------------
package crst_pkg;

   localparam int SEG_W = 6;                    // segments register width
   localparam int REM_W = 19;                   // holds 2*63^3
   localparam logic [SEG_W-1:0] SEG_RESET = 6'd8;

   // control from the sequencer to each lane
   typedef struct packed {
      logic start;   // latch control points, begin setup
      logic step;    // advance to next sample
   } lane_ctrl_type;

   // status from a lane back to the sequencer
   typedef struct packed {
      logic ready;   // setup finished, sample output valid
   } lane_stat_type;

endpackage

/* rtl/catmull_rom_spline_tessellator.sv */
// ----------------------------------------------------------------------------
// catmull_rom_spline_tessellator
// Streaming uniform Catmull-Rom tessellator: control points in, line beats out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | point x/y/z, final_point
//  rsp_    | out       | rsp_valid/rsp_stall  | start/end x/y/z, run_end, curve_end
//  csr_    | in        | csr_valid/csr_ready  | segments (6 bit)
//
//  A point that closes a span starts setup (three serial divisions per lane by
//  2*n^3, one bit per cycle), then n+1 samples, where n is segments, or 1
//  when segments is 0. A buffered point leaves the input free for the next.
//  A final point with fewer than four points held: lines of a plain polyline.
//  Reset is synchronous, active high; clears sequencer, point count, valids.
//  A stalled output holds its beat; the sequencer waits on the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module catmull_rom_spline_tessellator #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // control point input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic                          req_final_point,
   // line output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_start_x,
   output logic signed [COORD_WIDTH-1:0] rsp_start_y,
   output logic signed [COORD_WIDTH-1:0] rsp_start_z,
   output logic signed [COORD_WIDTH-1:0] rsp_end_x,
   output logic signed [COORD_WIDTH-1:0] rsp_end_y,
   output logic signed [COORD_WIDTH-1:0] rsp_end_z,
   output logic                          rsp_run_end,
   output logic                          rsp_curve_end,
   // segments register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [crst_pkg::SEG_W-1:0]    csr_segments
);

   localparam int W  = COORD_WIDTH;
   localparam int NW = crst_pkg::SEG_W;
   localparam int RW = crst_pkg::REM_W;

   typedef enum logic [1:0] {
      T_IDLE, T_POLY, T_SETUP, T_SAMPLE
   } state_type;

   state_type state_ff, state_in;

   // configuration and derived divisor 2*n^3
   logic [NW-1:0]   seg_ff, seg_in;
   logic [NW-1:0]   nz;
   logic [2*NW-1:0] n2_ff;
   logic [RW-1:0]   d_ff;

   // point history [index][axis], current point, sample history
   logic signed [W-1:0] rp_ff [3][3];
   logic signed [W-1:0] rp_in [3][3];
   logic signed [W-1:0] pt_ff [3];
   logic signed [W-1:0] pt_in [3];
   logic signed [W-1:0] prev_ff [3];
   logic signed [W-1:0] prev_in [3];
   logic signed [W-1:0] req_pt [3];
   logic signed [W-1:0] smp [3];
   logic                fin_ff, fin_in;
   logic [1:0]          count_ff, count_in;
   logic                pv_ff, pv_in;
   logic [NW-1:0]       s_ff, s_in;

   // output register
   logic                rv_ff, rv_in;
   logic signed [W-1:0] os_ff [3];
   logic signed [W-1:0] os_in [3];
   logic signed [W-1:0] oe_ff [3];
   logic signed [W-1:0] oe_in [3];
   logic                orun_ff, orun_in, ocrv_ff, ocrv_in;

   crst_pkg::lane_ctrl_type lane_ctrl;
   crst_pkg::lane_stat_type lane_stat [3];

   logic out_free, accept, last_s;

   assign req_pt[0] = req_point_x;
   assign req_pt[1] = req_point_y;
   assign req_pt[2] = req_point_z;

   assign nz       = (seg_ff == '0) ? {{(NW-1){1'b0}}, 1'b1} : seg_ff;
   assign out_free = !rv_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign last_s   = (s_ff == nz);
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != T_IDLE);

   // one lane per axis
   for (genvar g = 0; g < 3; g++) begin : g_lane
      crst_lane #(.W(W)) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .n      (nz),
         .d      (d_ff),
         .p0     (rp_ff[0][g]),
         .p1     (rp_ff[1][g]),
         .p2     (rp_ff[2][g]),
         .p3     (req_pt[g]),
         .stat   (lane_stat[g]),
         .sample (smp[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      seg_in   = (csr_valid && csr_ready) ? csr_segments : seg_ff;
      rp_in    = rp_ff;
      pt_in    = pt_ff;
      prev_in  = prev_ff;
      fin_in   = fin_ff;
      count_in = count_ff;
      pv_in    = pv_ff;
      s_in     = s_ff;
      rv_in    = rv_ff && rsp_stall;
      os_in    = os_ff;
      oe_in    = oe_ff;
      orun_in  = orun_ff;
      ocrv_in  = ocrv_ff;
      lane_ctrl.start = 1'b0;
      lane_ctrl.step  = 1'b0;

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               pt_in  = req_pt;
               fin_in = req_final_point;
               if (count_ff == 2'd3) begin
                  // this point closes a span
                  lane_ctrl.start = 1'b1;
                  s_in     = '0;
                  state_in = T_SETUP;
               end else if (req_final_point) begin
                  if (count_ff == 2'd0) begin
                     pv_in = 1'b0;      // lone point: no lines
                  end else begin
                     state_in = T_POLY;
                  end
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     if (count_ff == 2'(i)) rp_in[i] = req_pt;
                  end
                  count_in = count_ff + 2'd1;
               end
            end
         end
         T_POLY: begin
            // plain polyline, oldest point first; history shifts down
            if (out_free) begin
               rv_in   = 1'b1;
               os_in   = rp_ff[0];
               oe_in   = (count_ff == 2'd1) ? pt_ff : rp_ff[1];
               orun_in = (count_ff == 2'd1);
               ocrv_in = (count_ff == 2'd1);
               rp_in[0] = rp_ff[1];
               rp_in[1] = rp_ff[2];
               count_in = count_ff - 2'd1;
               if (count_ff == 2'd1) begin
                  pv_in    = 1'b0;
                  state_in = T_IDLE;
               end
            end
         end
         T_SETUP: begin
            if (lane_stat[0].ready) state_in = T_SAMPLE;
         end
         T_SAMPLE: begin
            if (out_free) begin
               lane_ctrl.step = 1'b1;
               if (pv_ff) begin
                  rv_in   = 1'b1;
                  os_in   = prev_ff;
                  oe_in   = smp;
                  orun_in = last_s;
                  ocrv_in = last_s && fin_ff;
               end
               prev_in = smp;
               pv_in   = 1'b1;
               if (last_s) begin
                  rp_in[0] = rp_ff[1];
                  rp_in[1] = rp_ff[2];
                  rp_in[2] = pt_ff;
                  if (fin_ff) begin
                     count_in = 2'd0;
                     pv_in    = 1'b0;
                  end
                  state_in = T_IDLE;
               end else begin
                  s_in = s_ff + {{(NW-1){1'b0}}, 1'b1};
               end
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         seg_ff   <= crst_pkg::SEG_RESET;
         count_ff <= 2'd0;
         pv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         count_ff <= count_in;
         pv_ff    <= pv_in;
         rv_ff    <= rv_in;
      end
      n2_ff   <= (2*NW)'(nz) * (2*NW)'(nz);
      d_ff    <= {(RW-1)'(n2_ff) * (RW-1)'(nz), 1'b0};
      rp_ff   <= rp_in;
      pt_ff   <= pt_in;
      prev_ff <= prev_in;
      fin_ff  <= fin_in;
      s_ff    <= s_in;
      os_ff   <= os_in;
      oe_ff   <= oe_in;
      orun_ff <= orun_in;
      ocrv_ff <= ocrv_in;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_start_x   = os_ff[0];
   assign rsp_start_y   = os_ff[1];
   assign rsp_start_z   = os_ff[2];
   assign rsp_end_x     = oe_ff[0];
   assign rsp_end_y     = oe_ff[1];
   assign rsp_end_z     = oe_ff[2];
   assign rsp_run_end   = orun_ff;
   assign rsp_curve_end = ocrv_ff;

   // a curve end beat always closes its run
   `CRST_CHECK(a_curve_has_run, !rv_ff || !ocrv_ff || orun_ff)
   // lanes run in lockstep
   `CRST_CHECK(a_lanes_lockstep,
      lane_stat[0].ready == lane_stat[1].ready && lane_stat[1].ready == lane_stat[2].ready)
   // sampling only with set-up lanes
   `CRST_CHECK(a_sample_ready, state_ff != T_SAMPLE || lane_stat[0].ready)
   // a finished span leaves the sample history valid unless the curve ended
   `CRST_CHECK_NEXT(a_span_history, state_ff == T_SAMPLE && out_free && last_s && !fin_ff,
      pv_ff && count_ff == 2'd3)

endmodule

/* rtl/crst_div.sv */
// ----------------------------------------------------------------------------
// crst_div
// Restoring divider, one quotient bit per cycle, floor quotient/remainder.
// ----------------------------------------------------------------------------
module crst_div #(
   parameter int DW = 46
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DW-1:0]            dividend,
   input  logic [crst_pkg::REM_W-1:0]      divisor,
   output logic                            done,
   output logic signed [DW:0]              quot,
   output logic [crst_pkg::REM_W-1:0]      rem
);

   localparam int RW = crst_pkg::REM_W;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] mag_ff, mag_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic          done_ff, done_in;
   logic signed [DW:0] quot_ff, quot_in;
   logic [RW-1:0] remo_ff, remo_in;

   logic [RW:0]   rem_sh, rem_nx;
   logic          fits;
   logic [DW-1:0] mag_nx;
   logic signed [DW:0] qpos;
   logic [DW-1:0] absd;

   always_comb begin
      rem_sh = {rem_ff, mag_ff[DW-1]};
      fits   = rem_sh >= {1'b0, divisor};
      rem_nx = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      mag_nx = {mag_ff[DW-2:0], fits};
      qpos   = $signed({1'b0, mag_nx});
      absd   = dividend[DW-1] ? (~dividend + {{(DW-1){1'b0}}, 1'b1}) : dividend;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      remo_in = remo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         neg_in  = dividend[DW-1];
         mag_in  = absd;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_nx[RW-1:0];
         mag_in = mag_nx;
         cnt_in = cnt_ff - {{(CW-1){1'b0}}, 1'b1};
         if (cnt_ff == {{(CW-1){1'b0}}, 1'b1}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // floor semantics for negative dividends
            if (neg_ff && (rem_nx != '0)) begin
               quot_in = -qpos - {{DW{1'b0}}, 1'b1};
               remo_in = divisor - rem_nx[RW-1:0];
            end else if (neg_ff) begin
               quot_in = -qpos;
               remo_in = '0;
            end else begin
               quot_in = qpos;
               remo_in = rem_nx[RW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      remo_ff <= remo_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = remo_ff;

endmodule

/* rtl/crst_lane.sv */
// ----------------------------------------------------------------------------
// crst_lane
// One coordinate axis: cubic setup, forward differences kept as
// floor quotient/remainder pairs over 2*n^3, truncated saturated sample.
// ----------------------------------------------------------------------------
module crst_lane #(
   parameter int W = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crst_pkg::lane_ctrl_type           ctrl,
   input  logic [crst_pkg::SEG_W-1:0]        n,
   input  logic [crst_pkg::REM_W-1:0]        d,
   input  logic signed [W-1:0]               p0,
   input  logic signed [W-1:0]               p1,
   input  logic signed [W-1:0]               p2,
   input  logic signed [W-1:0]               p3,
   output crst_pkg::lane_stat_type           stat,
   output logic signed [W-1:0]               sample
);

   localparam int DW = W + 14;
   localparam int QW = DW + 1;
   localparam int RW = crst_pkg::REM_W;
   localparam int NW = crst_pkg::SEG_W;
   localparam logic signed [QW-1:0] SMAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [QW-1:0] SMIN = {{(QW-W+1){1'b1}}, {(W-1){1'b0}}};

   typedef enum logic [2:0] {
      L_IDLE, L_MUL1, L_MUL2, L_DIV, L_RUN
   } lstate_type;

   lstate_type state_ff, state_in;
   logic signed [DW-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [DW-1:0] t1_ff, t1_in, d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic [1:0]           sel_ff, sel_in;
   logic                 go_ff, go_in;
   logic signed [QW-1:0] fq_ff, fq_in, q1_ff, q1_in, q2_ff, q2_in, q3_ff, q3_in;
   logic [RW-1:0]        fr_ff, fr_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;

   logic signed [DW-1:0] e0, e1, e2, e3, div_arg;
   logic signed [NW:0]   ns;
   logic signed [NW+1:0] ns2;
   logic                 div_done;
   logic signed [QW-1:0] div_q;
   logic [RW-1:0]        div_r;
   logic [QW+RW-1:0]     nf, n1, n2;
   logic signed [QW-1:0] trunc;

   // sum of two floor pairs over the same divisor
   function automatic logic [QW+RW-1:0] qr_add(
      input logic signed [QW-1:0] qa, input logic [RW-1:0] ra,
      input logic signed [QW-1:0] qb, input logic [RW-1:0] rb,
      input logic [RW-1:0] dv);
      logic [RW:0]          rs;
      logic signed [QW-1:0] qs;
      rs = {1'b0, ra} + {1'b0, rb};
      qs = qa + qb;
      if (rs >= {1'b0, dv}) begin
         rs = rs - {1'b0, dv};
         qs = qs + {{(QW-1){1'b0}}, 1'b1};
      end
      return {qs, rs[RW-1:0]};
   endfunction

   crst_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (div_arg),
      .divisor  (d),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   always_comb begin
      e0  = DW'(p0);
      e1  = DW'(p1);
      e2  = DW'(p2);
      e3  = DW'(p3);
      ns  = $signed({1'b0, n});
      ns2 = $signed({1'b0, n, 1'b0});
      case (sel_ff)
         2'd0:    div_arg = d1_ff;
         2'd1:    div_arg = d2_ff;
         default: div_arg = d3_ff;
      endcase
      nf = qr_add(fq_ff, fr_ff, q1_ff, r1_ff, d);
      n1 = qr_add(q1_ff, r1_ff, q2_ff, r2_ff, d);
      n2 = qr_add(q2_ff, r2_ff, q3_ff, r3_ff, d);

      // floor -> truncate toward zero, then clamp
      trunc = fq_ff + ((fq_ff < 0 && fr_ff != '0) ? {{(QW-1){1'b0}}, 1'b1} : '0);
      if (trunc > SMAX)      sample = SMAX[W-1:0];
      else if (trunc < SMIN) sample = SMIN[W-1:0];
      else                   sample = trunc[W-1:0];

      state_in = state_ff;
      a_in = a_ff;  b_in = b_ff;  c_in = c_ff;
      t1_in = t1_ff; d1_in = d1_ff; d2_in = d2_ff; d3_in = d3_ff;
      sel_in = sel_ff;
      go_in  = 1'b0;
      fq_in = fq_ff; fr_in = fr_ff;
      q1_in = q1_ff; r1_in = r1_ff;
      q2_in = q2_ff; r2_in = r2_ff;
      q3_in = q3_ff; r3_in = r3_ff;

      if (ctrl.start) begin
         a_in  = e2 - e0;
         b_in  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
         c_in  = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
         fq_in = QW'(p1);               // f(0) / 2n^3 is P1 exactly
         fr_in = '0;
         state_in = L_MUL1;
      end else begin
         case (state_ff)
            L_MUL1: begin
               t1_in = a_ff * ns + b_ff;
               d2_in = b_ff * ns2 + (c_ff <<< 2) + (c_ff <<< 1);
               d3_in = (c_ff <<< 2) + (c_ff <<< 1);
               state_in = L_MUL2;
            end
            L_MUL2: begin
               d1_in  = t1_ff * ns + c_ff;
               sel_in = 2'd0;
               go_in  = 1'b1;
               state_in = L_DIV;
            end
            L_DIV: begin
               if (div_done) begin
                  case (sel_ff)
                     2'd0: begin
                        q1_in = div_q; r1_in = div_r;
                     end
                     2'd1: begin
                        q2_in = div_q; r2_in = div_r;
                     end
                     default: begin
                        q3_in = div_q; r3_in = div_r;
                     end
                  endcase
                  if (sel_ff == 2'd2) begin
                     state_in = L_RUN;
                  end else begin
                     sel_in = sel_ff + 2'd1;
                     go_in  = 1'b1;
                  end
               end
            end
            L_RUN: begin
               if (ctrl.step) begin
                  {fq_in, fr_in} = nf;
                  {q1_in, r1_in} = n1;
                  {q2_in, r2_in} = n2;
               end
            end
            default: state_in = L_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
      a_ff <= a_in;  b_ff <= b_in;  c_ff <= c_in;
      t1_ff <= t1_in; d1_ff <= d1_in; d2_ff <= d2_in; d3_ff <= d3_in;
      sel_ff <= sel_in;
      fq_ff <= fq_in; fr_ff <= fr_in;
      q1_ff <= q1_in; r1_ff <= r1_in;
      q2_ff <= q2_in; r2_ff <= r2_in;
      q3_ff <= q3_in; r3_ff <= r3_in;
   end

   assign stat.ready = (state_ff == L_RUN);

endmodule
